### hdl/sm3_pkg.sv
// SM3 hash engine shared types, constants and round functions.
`timescale 1ns / 1ps
package sm3_pkg;

   localparam logic [31:0] IV0 = 32'h7380166F;
   localparam logic [31:0] IV1 = 32'h4914B2B9;
   localparam logic [31:0] IV2 = 32'h172442D7;
   localparam logic [31:0] IV3 = 32'hDA8A0600;
   localparam logic [31:0] IV4 = 32'hA96F30BC;
   localparam logic [31:0] IV5 = 32'h163138AA;
   localparam logic [31:0] IV6 = 32'hE38DEE4D;
   localparam logic [31:0] IV7 = 32'hB0FB0E4E;
   localparam logic [31:0] T_LOW = 32'h79CC4519;
   localparam logic [31:0] T_HIGH = 32'h7A879D8A;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int QUEUE_DEPTH = 4;

   // Block handed from front to back: 16 message words, final flag.
   typedef struct packed {
      logic [511:0] block;
      logic         final_block;
   } blk_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } bstate_type;

   typedef enum logic [1:0] {
      FS_FILL,
      FS_PAD_ZERO,
      FS_PAD_LEN
   } fstate_type;

   function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      begin
         d = {x, x} << n;
         rol = d[63:32];
      end
   endfunction

   function automatic logic [31:0] p0(input logic [31:0] x);
      p0 = x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
   endfunction

   function automatic logic [31:0] p1(input logic [31:0] x);
      p1 = x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
   endfunction

endpackage

### hdl/sm3_front.sv
// SM3 front end: gathers bytes into blocks, pads the final block, counts length.
`timescale 1ns / 1ps
module sm3_front import sm3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic [1:0]   req_tuser,
   output logic         blk_valid,
   input  logic         blk_ready,
   output blk_type      blk_data
);

   fstate_type   state_ff, state_in;
   logic [511:0] buf_ff, buf_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  count_ff, count_in;
   logic         has_byte, is_last;
   logic         out_valid_ff, out_valid_in;
   blk_type      out_ff, out_in;
   logic         take;
   logic [63:0]  bits;

   assign has_byte = req_tuser[0];
   assign is_last = req_tuser[1];
   assign req_tready = (state_ff == FS_FILL) && !out_valid_ff;
   assign take = req_tvalid && req_tready;
   assign blk_valid = out_valid_ff;
   assign blk_data = out_ff;
   assign bits = {count_ff[60:0], 3'b000};

   always_comb begin
      logic [511:0] b;
      logic [6:0]   pos;
      b = buf_ff;
      pos = {1'b0, fill_ff};
      state_in = state_ff;
      fill_in = fill_ff;
      count_in = count_ff;
      out_valid_in = out_valid_ff && !blk_ready;
      out_in = out_ff;
      case (state_ff)
         FS_FILL: begin
            if (take) begin
               if (has_byte) begin
                  b[511 - 8*fill_ff -: 8] = req_tdata;
                  count_in = count_ff + 64'd1;
                  pos = pos + 7'd1;
               end
               if (is_last) begin
                  if (pos == 7'd64) begin
                     out_valid_in = 1'b1;
                     out_in = '{block: b, final_block: 1'b0};
                     pos = 7'd0;
                  end
                  b[511 - 8*pos[5:0] -: 8] = PAD_BYTE;
                  for (int i = 0; i < 64; i++)
                     if (i > pos) b[511 - 8*i -: 8] = 8'h00;
                  fill_in = 6'd0;
                  state_in = (pos >= 7'd56) ? FS_PAD_ZERO : FS_PAD_LEN;
               end else if (pos == 7'd64) begin
                  out_valid_in = 1'b1;
                  out_in = '{block: b, final_block: 1'b0};
                  fill_in = 6'd0;
               end else begin
                  fill_in = pos[5:0];
               end
            end
         end
         FS_PAD_ZERO: begin
            if (!out_valid_ff || blk_ready) begin
               out_valid_in = 1'b1;
               out_in = '{block: b, final_block: 1'b0};
               b = '0;
               state_in = FS_PAD_LEN;
            end
         end
         FS_PAD_LEN: begin
            if (!out_valid_ff || blk_ready) begin
               out_valid_in = 1'b1;
               out_in = '{block: {b[511:64], bits}, final_block: 1'b1};
               count_in = 64'd0;
               state_in = FS_FILL;
            end
         end
         default: state_in = FS_FILL;
      endcase
      buf_in = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_FILL;
         fill_ff <= 6'd0;
         count_ff <= 64'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
      buf_ff <= buf_in;
      out_ff <= out_in;
   end

endmodule

### hdl/sm3_queue.sv
// Short FIFO of blocks between the front end and the compression core.
`timescale 1ns / 1ps
module sm3_queue import sm3_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  blk_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output blk_type out_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   blk_type        mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           push, pop;

   assign in_ready = cnt_ff != (AW+1)'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end

endmodule

### hdl/sm3_core.sv
// SM3 compression core: one round per cycle, digest output after a final block.
`timescale 1ns / 1ps
module sm3_core import sm3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         blk_valid,
   output logic         blk_ready,
   input  blk_type      blk_data,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast
);

   bstate_type    state_ff, state_in;
   logic [31:0]   v_ff [8];
   logic [31:0]   r_ff [8];
   logic [31:0]   r_in [8];
   logic [31:0]   w_ff [16];
   logic [31:0]   w_in [16];
   logic [5:0]    rnd_ff, rnd_in;
   logic [2:0]    idx_ff, idx_in;
   logic          fin_ff;
   logic          load, fold, emit_done;
   logic [31:0]   a12, ss1, ss2, ffv, ggv, tt1, tt2, tc, wnew;
   logic          early;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (blk_valid) state_in = ST_ROUND;
         ST_ROUND: if (rnd_ff == 6'd63) state_in = ST_FOLD;
         ST_FOLD:  state_in = fin_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT:  if (emit_done) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      blk_ready = state_ff == ST_IDLE;
      load = blk_valid && blk_ready;
      fold = state_ff == ST_FOLD;
      rsp_tvalid = state_ff == ST_EMIT;
      emit_done = rsp_tvalid && rsp_tready && idx_ff == 3'd7;
      rsp_tdata = v_ff[idx_ff];
      rsp_tuser = idx_ff;
      rsp_tlast = idx_ff == 3'd7;
   end

   always_comb begin
      early = rnd_ff < 6'd16;
      tc = early ? T_LOW : T_HIGH;
      a12 = rol(r_ff[0], 5'd12);
      ss1 = rol(a12 + r_ff[4] + rol(tc, rnd_ff[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      ffv = early ? (r_ff[0] ^ r_ff[1] ^ r_ff[2])
                  : ((r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]));
      ggv = early ? (r_ff[4] ^ r_ff[5] ^ r_ff[6])
                  : ((r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]));
      tt1 = ffv + r_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = ggv + r_ff[7] + ss1 + w_ff[0];
      wnew = p1(w_ff[0] ^ w_ff[7] ^ rol(w_ff[13], 5'd15)) ^ rol(w_ff[3], 5'd7) ^ w_ff[10];
      for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
      w_in[15] = wnew;
      r_in[0] = tt1;
      r_in[1] = r_ff[0];
      r_in[2] = rol(r_ff[1], 5'd9);
      r_in[3] = r_ff[2];
      r_in[4] = p0(tt2);
      r_in[5] = r_ff[4];
      r_in[6] = rol(r_ff[5], 5'd19);
      r_in[7] = r_ff[6];
      rnd_in = (state_ff == ST_ROUND) ? rnd_ff + 6'd1 : 6'd0;
      idx_in = idx_ff;
      if (rsp_tvalid && rsp_tready) idx_in = idx_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff <= 6'd0;
         idx_ff <= 3'd0;
         v_ff[0] <= IV0; v_ff[1] <= IV1; v_ff[2] <= IV2; v_ff[3] <= IV3;
         v_ff[4] <= IV4; v_ff[5] <= IV5; v_ff[6] <= IV6; v_ff[7] <= IV7;
      end else begin
         state_ff <= state_in;
         rnd_ff <= rnd_in;
         idx_ff <= idx_in;
         if (fold) begin
            for (int i = 0; i < 8; i++) v_ff[i] <= v_ff[i] ^ r_ff[i];
         end else if (emit_done) begin
            v_ff[0] <= IV0; v_ff[1] <= IV1; v_ff[2] <= IV2; v_ff[3] <= IV3;
            v_ff[4] <= IV4; v_ff[5] <= IV5; v_ff[6] <= IV6; v_ff[7] <= IV7;
         end
      end
      if (load) begin
         fin_ff <= blk_data.final_block;
         for (int i = 0; i < 16; i++) w_ff[i] <= blk_data.block[511 - 32*i -: 32];
         for (int i = 0; i < 8; i++) r_ff[i] <= v_ff[i];
      end else if (state_ff == ST_ROUND) begin
         w_ff <= w_in;
         r_ff <= r_in;
      end
   end

endmodule

### hdl/sm3_hash_engine.sv
// SM3 hash engine top level: front end, block queue and compression core.
`timescale 1ns / 1ps
// Bytes enter one per cycle on req_* while req_tready is high; every 64
// bytes form a block that is queued for the compression core. The core
// loads a block, runs its rounds and then folds it into the chaining value.
// The front end pauses while it hands a block on. The queue holds four
// blocks, so a steady stream is paced by the core. An item with tuser[1]
// set pads the message (one or two final blocks), and after its blocks are
// compressed the 256-bit digest leaves on rsp_* as eight 32-bit words, most
// significant first, tlast on the eighth. The block then starts a fresh
// message.
module sm3_hash_engine import sm3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic [1:0]   req_tuser,   // has_byte, is_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // digest_word
   output logic [2:0]   rsp_tuser,   // word_index
   output logic         rsp_tlast    // last_word
);

   logic    f_valid, f_ready, q_valid, q_ready;
   blk_type f_data, q_data;

   sm3_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .blk_valid(f_valid), .blk_ready(f_ready), .blk_data(f_data)
   );

   sm3_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   sm3_core u_core (
      .clock, .reset, .blk_valid(q_valid), .blk_ready(q_ready), .blk_data(q_data),
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

endmodule

### tb/tb_sm3_hash_engine.sv
// Self-checking testbench for the streaming SM3 hash engine.
`timescale 1ns / 1ps
module tb_sm3_hash_engine;
   import sm3_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 1500;
   localparam int DRAIN_CYCLES = 400;
   localparam int MIN_ITEMS = 320;
   localparam logic [1:0] RX_OPEN = 2'd0;
   localparam logic [1:0] RX_COIN = 2'd1;
   localparam logic [1:0] RX_RARE = 2'd2;
   localparam logic [1:0] RX_HEAVY = 2'd3;

   typedef struct {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } byte_item_type;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // data_byte
   logic [1:0]  req_tuser = '0;   // has_byte, is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // digest_word
   logic [2:0]  rsp_tuser;        // word_index
   logic        rsp_tlast;        // last_word

   byte_item_type   pending_bytes[$];
   digest_word_type expected_digest[$];
   logic [31:0]     hash_state[8];
   logic [7:0]      block_bytes[64];
   int              block_fill;
   logic [63:0]     message_len;
   int              burst_left = 0;
   int              gap_left = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;
   int              accepted_items = 0;
   int              rx_phase = 0;
   logic [1:0]      rx_mode = RX_OPEN;
   int              error_count = 0;
   int              cycle_count = 0;

   sm3_hash_engine DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] rotl32(logic [31:0] x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void compress_block();
      logic [31:0] w[68];
      logic [31:0] a, b, c, d, e, f, g, h, tc, a12, ss1, ss2, ffv, ggv, tt1, tt2;
      for (int k = 0; k < 16; k++)
         w[k] = {block_bytes[4*k], block_bytes[4*k+1], block_bytes[4*k+2], block_bytes[4*k+3]};
      for (int k = 16; k < 68; k++) begin
         tc = w[k-16] ^ w[k-9] ^ rotl32(w[k-3], 15);
         w[k] = tc ^ rotl32(tc, 15) ^ rotl32(tc, 23) ^ rotl32(w[k-13], 7) ^ w[k-6];
      end
      {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                  hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
      for (int k = 0; k < 64; k++) begin
         tc = (k < 16) ? T_LOW : T_HIGH;
         a12 = rotl32(a, 12);
         ss1 = rotl32(a12 + e + rotl32(tc, k), 7);
         ss2 = ss1 ^ a12;
         ffv = (k < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
         ggv = (k < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
         tt1 = ffv + d + ss2 + (w[k] ^ w[k+4]);
         tt2 = ggv + h + ss1 + w[k];
         d = c;
         c = rotl32(b, 9);
         b = a;
         a = tt1;
         h = g;
         g = rotl32(f, 19);
         f = e;
         e = tt2 ^ rotl32(tt2, 9) ^ rotl32(tt2, 17);
      end
      hash_state[0] ^= a; hash_state[1] ^= b; hash_state[2] ^= c; hash_state[3] ^= d;
      hash_state[4] ^= e; hash_state[5] ^= f; hash_state[6] ^= g; hash_state[7] ^= h;
   endfunction

   function automatic void start_message();
      hash_state = '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
      block_fill = 0;
      message_len = '0;
   endfunction

   function automatic void hash_item(byte_item_type it);
      int pos;
      logic [63:0] bits;
      digest_word_type dw;
      if (it.has_byte) begin
         block_bytes[block_fill] = it.data_byte;
         block_fill++;
         message_len++;
         if (block_fill == 64) begin
            compress_block();
            block_fill = 0;
         end
      end
      if (!it.is_last) return;
      block_bytes[block_fill] = PAD_BYTE;
      pos = block_fill + 1;
      if (pos > 56) begin
         while (pos < 64) begin
            block_bytes[pos] = 8'h00;
            pos++;
         end
         compress_block();
         pos = 0;
      end
      while (pos < 56) begin
         block_bytes[pos] = 8'h00;
         pos++;
      end
      bits = message_len << 3;
      for (int k = 0; k < 8; k++) block_bytes[56+k] = bits[63-8*k -: 8];
      compress_block();
      for (int k = 0; k < 8; k++) begin
         dw.word = hash_state[k];
         dw.index = 3'(k);
         dw.last = (k == 7);
         expected_digest = {expected_digest, dw};
      end
      start_message();
   endfunction

   function automatic void add_item(logic [7:0] v, logic hb, logic lst);
      byte_item_type it;
      it.data_byte = v;
      it.has_byte = hb;
      it.is_last = lst;
      pending_bytes = {pending_bytes, it};
   endfunction

   function automatic void add_message(int len, bit noisy);
      bit last_on_byte;
      last_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if (noisy && $urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
         add_item(8'($urandom), 1'b1, last_on_byte && (i == len - 1));
      end
      if (!last_on_byte) add_item(8'($urandom), 1'b0, 1'b1);
   endfunction

   // sender: bursts and gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            byte_item_type it;
            it.data_byte = req_tdata;
            it.has_byte = req_tuser[0];
            it.is_last = req_tuser[1];
            hash_item(it);
            accepted_items++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               byte_item_type it;
               it = pending_bytes.pop_front();
               req_tdata <= it.data_byte;
               req_tuser <= {it.is_last, it.has_byte};
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 60);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: changing stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && accepted_items > 40 && expected_digest.size() > 0) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rx_phase++;
         if (rx_phase % 150 == 0) rx_mode = 2'($urandom_range(0, 3));
         case (rx_mode)
            RX_OPEN:  rsp_tready <= 1'b1;
            RX_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
            RX_RARE:  rsp_tready <= ($urandom_range(0, 7) != 0);
            default:  rsp_tready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         digest_word_type dw;
         if (expected_digest.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected digest word %h index %0d", rsp_tdata, rsp_tuser);
         end else begin
            dw = expected_digest.pop_front();
            if (rsp_tdata !== dw.word || rsp_tuser !== dw.index || rsp_tlast !== dw.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                           dw.word, dw.index, dw.last, rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int len, sel;
      start_message();
      for (int k = 0; k < 64; k++) block_bytes[k] = 8'h00;
      // empty message, "abc", idle item, extreme bytes, last without a byte
      add_item(8'hFF, 1'b0, 1'b1);
      add_item(8'h61, 1'b1, 1'b0);
      add_item(8'h62, 1'b1, 1'b0);
      add_item(8'h63, 1'b1, 1'b1);
      add_item(8'hA5, 1'b0, 1'b0);
      add_item(8'h00, 1'b1, 1'b0);
      add_item(8'hFF, 1'b1, 1'b0);
      add_item(8'h00, 1'b0, 1'b1);
      add_item(8'h00, 1'b1, 1'b1);
      for (int i = 0; i < 55; i++) add_item(8'($urandom), 1'b1, 1'b0);
      add_item(8'h5A, 1'b0, 1'b1);
      for (int i = 0; i < 56; i++) add_item(8'($urandom), 1'b1, i == 55);
      while (pending_bytes.size() < MIN_ITEMS) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0: len = $urandom_range(0, 3);
            1: len = $urandom_range(54, 57);
            2: len = $urandom_range(62, 65);
            3: len = $urandom_range(118, 121);
            default: len = $urandom_range(1, 40);
         endcase
         add_message(len, 1'b1);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending_bytes.size() == 0 && !req_tvalid && expected_digest.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_digest.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
hdl/sm3_pkg.sv
hdl/sm3_front.sv
hdl/sm3_queue.sv
hdl/sm3_core.sv
hdl/sm3_hash_engine.sv
tb/tb_sm3_hash_engine.sv
